// ===== design/tcpu_pkg.sv =====
`timescale 1ns / 1ps

package tcpu_pkg;

    localparam int MEM_ROWS_DEF  = 16;
    localparam int DATA_BITS_DEF = 8;

    // request types
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_EXEC   = 2'd1;
    localparam logic [1:0] REQ_RESUME = 2'd2;

    // opcodes, bits 15:12 of a cell
    localparam logic [3:0] OP_STOP = 4'd1;
    localparam logic [3:0] OP_OUT  = 4'd2;
    localparam logic [3:0] OP_JMP  = 4'd3;
    localparam logic [3:0] OP_LOAD = 4'd4;
    localparam logic [3:0] OP_OUTR = 4'd5;
    localparam logic [3:0] OP_ADD  = 4'd6;
    localparam logic [3:0] OP_CMP  = 4'd7;
    localparam logic [3:0] OP_JIF  = 4'd8;

    // register codes
    localparam logic [1:0] RC_A    = 2'd0;
    localparam logic [1:0] RC_B    = 2'd1;
    localparam logic [1:0] RC_C    = 2'd2;
    localparam logic [1:0] RC_NONE = 2'd3;

    // jump conditions
    localparam logic [1:0] COND_EQ = 2'd0;
    localparam logic [1:0] COND_LT = 2'd1;
    localparam logic [1:0] COND_GT = 2'd2;

    // bit positions in the flag word
    localparam int FLAG_EQ_BIT = 0;
    localparam int FLAG_LT_BIT = 1;
    localparam int FLAG_GT_BIT = 2;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_value;
        logic [4:0] prog_counter;
        logic       halted;
        logic       flag_eq;
        logic       flag_lt;
        logic       flag_gt;
        logic [7:0] reg_a_value;
        logic [7:0] reg_b_value;
        logic [7:0] reg_c_value;
    } result_t;

endpackage

// ===== design/tcpu_req_if.sv =====
`timescale 1ns / 1ps

interface tcpu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  cell_addr;
    logic [15:0] cell_word;

    modport source (output valid, output req_type, output cell_addr, output cell_word,
                    input ready);
    modport sink (input valid, input req_type, input cell_addr, input cell_word,
                  output ready);
endinterface

// ===== design/tcpu_rsp_if.sv =====
`timescale 1ns / 1ps

interface tcpu_rsp_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_value;
    logic [4:0] prog_counter;
    logic       halted;
    logic       flag_eq;
    logic       flag_lt;
    logic       flag_gt;
    logic [7:0] reg_a_value;
    logic [7:0] reg_b_value;
    logic [7:0] reg_c_value;

    modport source (output valid, output out_valid, output out_value, output prog_counter,
                    output halted, output flag_eq, output flag_lt, output flag_gt,
                    output reg_a_value, output reg_b_value, output reg_c_value,
                    input ready);
    modport sink (input valid, input out_valid, input out_value, input prog_counter,
                  input halted, input flag_eq, input flag_lt, input flag_gt,
                  input reg_a_value, input reg_b_value, input reg_c_value,
                  output ready);
endinterface

// ===== design/tcpu_ram.sv =====
`timescale 1ns / 1ps

module tcpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tcpu_core.sv =====
`timescale 1ns / 1ps

module tcpu_core import tcpu_pkg::*; #(
    parameter int MEM_ROWS  = MEM_ROWS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcpu_req_if.sink   req,
    input  logic       res_free,
    output logic       res_push,
    output result_t    res
);

    localparam int AW    = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
    localparam int MAXPC = (MEM_ROWS > 15) ? MEM_ROWS : 15;
    localparam int PCW   = $clog2(MAXPC + 1);
    localparam int DW    = DATA_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_EXEC   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [PCW-1:0]       pc_reg, pc_next;
    logic [DW-1:0]        a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [2:0]           flags_reg, flags_next;
    logic                 halt_reg, halt_next;
    logic [7:0]           obyte_reg, obyte_next;
    logic                 shown_reg, shown_next;
    logic                 rvld_reg, rvld_next;
    logic [MEM_ROWS-1:0]  row_vld_reg, row_vld_next;
    logic [15:0]          inst_reg, inst_next;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [15:0]          mem_rdata;

    logic [AW+3:0]        addr_ext, row_ext, ex_row_ext;
    logic                 addr_ok, row_ok, pc_ok;
    logic [15:0]          word_q;
    logic [DW+15:0]       dat_ext;
    logic [DW-1:0]        dat, r54, r32, r10, sum;
    logic [PCW-1:0]       pc_inc, pc_row;
    logic [PCW+3:0]       pc_row_ext;
    logic [PCW+4:0]       pc_out_ext;
    logic [3:0]           op;
    logic                 taken;

    function automatic logic [DW-1:0] read_reg(input logic [1:0] code,
                                               input logic [DW-1:0] ra,
                                               input logic [DW-1:0] rb,
                                               input logic [DW-1:0] rc);
        logic [DW-1:0] v;
        case (code)
            RC_A:    v = ra;
            RC_B:    v = rb;
            RC_C:    v = rc;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] to_byte(input logic [DW-1:0] v);
        logic [DW+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

    tcpu_ram #(
        .WIDTH (16),
        .DEPTH (MEM_ROWS)
    ) u_prog_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_ext[AW-1:0]),
        .wdata (req.cell_word),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // a row never written reads as zero
    assign word_q     = rvld_reg ? mem_rdata : 16'd0;
    assign addr_ext   = {{AW{1'b0}}, req.cell_addr};
    assign addr_ok    = addr_ext < (AW + 4)'(MEM_ROWS);
    assign row_ext    = {{AW{1'b0}}, word_q[3:0]};
    assign row_ok     = row_ext < (AW + 4)'(MEM_ROWS);
    assign pc_ok      = pc_reg < PCW'(MEM_ROWS);

    assign op         = inst_reg[15:12];
    assign ex_row_ext = {{AW{1'b0}}, inst_reg[3:0]};
    assign dat_ext    = {{DW{1'b0}}, word_q};
    assign dat        = dat_ext[DW-1:0];
    assign r54        = read_reg(inst_reg[5:4], a_reg, b_reg, c_reg);
    assign r32        = read_reg(inst_reg[3:2], a_reg, b_reg, c_reg);
    assign r10        = read_reg(inst_reg[1:0], a_reg, b_reg, c_reg);
    assign sum        = r54 + r32;
    assign pc_inc     = pc_reg + PCW'(1);
    assign pc_row_ext = {{PCW{1'b0}}, inst_reg[3:0]};
    assign pc_row     = pc_row_ext[PCW-1:0];

    always_comb
    begin
        case (inst_reg[5:4])
            COND_EQ: taken = flags_reg[FLAG_EQ_BIT];
            COND_LT: taken = flags_reg[FLAG_LT_BIT];
            COND_GT: taken = flags_reg[FLAG_GT_BIT];
            default: taken = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        flags_next   = flags_reg;
        halt_next    = halt_reg;
        obyte_next   = obyte_reg;
        shown_next   = shown_reg;
        rvld_next    = rvld_reg;
        row_vld_next = row_vld_reg;
        inst_next    = inst_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = pc_reg[AW-1:0];
        res_push     = 1'b0;
        req.ready    = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    shown_next = 1'b0;
                    state_next = ST_DONE;
                    case (req.req_type)
                        REQ_WRITE:
                        begin
                            if (addr_ok)
                            begin
                                mem_we = 1'b1;
                                row_vld_next[addr_ext[AW-1:0]] = 1'b1;
                            end
                        end
                        REQ_EXEC:
                        begin
                            if (!halt_reg)
                            begin
                                if (!pc_ok)
                                begin
                                    halt_next = 1'b1;
                                end
                                else
                                begin
                                    // instruction fetch
                                    mem_re     = 1'b1;
                                    rvld_next  = row_vld_reg[pc_reg[AW-1:0]];
                                    state_next = ST_DECODE;
                                end
                            end
                        end
                        REQ_RESUME:
                        begin
                            halt_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DECODE:
            begin
                // latch the instruction and read its operand row
                inst_next  = word_q;
                mem_re     = 1'b1;
                mem_raddr  = row_ext[AW-1:0];
                rvld_next  = row_ok && row_vld_reg[row_ext[AW-1:0]];
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                case (op)
                    OP_STOP:
                    begin
                        halt_next = 1'b1;
                    end
                    OP_OUT:
                    begin
                        obyte_next = (ex_row_ext < (AW + 4)'(MEM_ROWS)) ? to_byte(dat) : 8'd0;
                        shown_next = 1'b1;
                        pc_next    = pc_inc;
                    end
                    OP_JMP:
                    begin
                        pc_next = pc_row;
                    end
                    OP_LOAD:
                    begin
                        case (inst_reg[5:4])
                            RC_A:    a_next = dat;
                            RC_B:    b_next = dat;
                            RC_C:    c_next = dat;
                            default: ;
                        endcase
                        pc_next = pc_inc;
                    end
                    OP_OUTR:
                    begin
                        if (inst_reg[1:0] != RC_NONE)
                        begin
                            obyte_next = to_byte(r10);
                        end
                        shown_next = 1'b1;
                        pc_next    = pc_inc;
                    end
                    OP_ADD:
                    begin
                        case (inst_reg[1:0])
                            RC_A:    a_next = sum;
                            RC_B:    b_next = sum;
                            RC_C:    c_next = sum;
                            default: ;
                        endcase
                        pc_next = pc_inc;
                    end
                    OP_CMP:
                    begin
                        flags_next = 3'b000;
                        if (r32 == r10)
                        begin
                            flags_next[FLAG_EQ_BIT] = 1'b1;
                        end
                        else if (r32 < r10)
                        begin
                            flags_next[FLAG_LT_BIT] = 1'b1;
                        end
                        else
                        begin
                            flags_next[FLAG_GT_BIT] = 1'b1;
                        end
                        pc_next = pc_inc;
                    end
                    OP_JIF:
                    begin
                        pc_next = taken ? pc_row : pc_inc;
                    end
                    default:
                    begin
                    end
                endcase
                if (pc_next >= PCW'(MEM_ROWS))
                begin
                    halt_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_free)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            c_reg       <= '0;
            flags_reg   <= '0;
            halt_reg    <= 1'b0;
            obyte_reg   <= '0;
            shown_reg   <= 1'b0;
            rvld_reg    <= 1'b0;
            row_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            flags_reg   <= flags_next;
            halt_reg    <= halt_next;
            obyte_reg   <= obyte_next;
            shown_reg   <= shown_next;
            rvld_reg    <= rvld_next;
            row_vld_reg <= row_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inst_reg <= inst_next;
    end

    assign pc_out_ext       = {5'd0, pc_reg};
    assign res.out_valid    = shown_reg;
    assign res.out_value    = obyte_reg;
    assign res.prog_counter = pc_out_ext[4:0];
    assign res.halted       = halt_reg;
    assign res.flag_eq      = flags_reg[FLAG_EQ_BIT];
    assign res.flag_lt      = flags_reg[FLAG_LT_BIT];
    assign res.flag_gt      = flags_reg[FLAG_GT_BIT];
    assign res.reg_a_value  = to_byte(a_reg);
    assign res.reg_b_value  = to_byte(b_reg);
    assign res.reg_c_value  = to_byte(c_reg);

endmodule

// ===== design/tiny_three_register_cpu_step_top.sv =====
`timescale 1ns / 1ps

// channel | side | handshake     | beat carries
// req     | sink | valid / ready | req_type, cell_addr, cell_word
// rsp     | src  | valid / ready | out_valid, out_value, prog_counter, halted,
//         |      |               | flag_eq/lt/gt, reg_a/b/c_value
//
// write, resume, ignored or halted execute: idle, done; execute: idle, decode, exec, done
// no new request is taken until done pushes its response; the one read port is used twice
// in turn (instruction fetch, then operand row) before the execute cycle
// reset is asynchronous; per-row valid bits make every row read as zero, no clearing pass
// a response held by rsp back-pressure does not block the next request beat, which
// then finishes and waits until the response register frees

module tiny_three_register_cpu_step_top import tcpu_pkg::*; #(
    parameter int MEM_ROWS  = MEM_ROWS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcpu_req_if.sink   req,
    tcpu_rsp_if.source rsp
);

    logic    res_push, res_free;
    result_t core_res;
    result_t res_reg;
    logic    res_vld_reg, res_vld_next;

    tcpu_core #(
        .MEM_ROWS  (MEM_ROWS),
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res_free (res_free),
        .res_push (res_push),
        .res      (core_res)
    );

    assign res_free = !res_vld_reg || rsp.ready;

    always_comb
    begin
        res_vld_next = res_vld_reg;
        if (res_push)
        begin
            res_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= core_res;
        end
    end

    assign rsp.valid        = res_vld_reg;
    assign rsp.out_valid    = res_reg.out_valid;
    assign rsp.out_value    = res_reg.out_value;
    assign rsp.prog_counter = res_reg.prog_counter;
    assign rsp.halted       = res_reg.halted;
    assign rsp.flag_eq      = res_reg.flag_eq;
    assign rsp.flag_lt      = res_reg.flag_lt;
    assign rsp.flag_gt      = res_reg.flag_gt;
    assign rsp.reg_a_value  = res_reg.reg_a_value;
    assign rsp.reg_b_value  = res_reg.reg_b_value;
    assign rsp.reg_c_value  = res_reg.reg_c_value;

    // the core never overwrites a response that is still waiting
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!res_vld_reg || rsp.ready))
        else $error("response pushed into a full register");

    // one request at a time: no request beat right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while the previous one is in flight");

    // a response leaves only through a completed beat
    a_drop_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_vld_reg) |-> $past(rsp.ready))
        else $error("response dropped without a beat");

    // a write beat with an empty response register is pushed on the next cycle
    a_push_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.req_type == REQ_WRITE) && !res_vld_reg)
        |=> res_push)
        else $error("write request did not complete");

endmodule
